>>> design/bsc_pkg.sv
package bsc_pkg;

  localparam int unsigned FRONT_DEPTH = 2;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [63:0] T_OFFSET = 64'd128000;
  localparam logic [63:0] P_BASE   = 64'd1048576;
  localparam logic [63:0] P_SCALE  = 64'd3125;
  localparam int unsigned P_ONE_SH = 47;
  localparam int unsigned P_DIV_SH = 33;
  localparam logic [31:0] T_ROUND  = 32'd128;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CALIB_VALID = 4'd0,
    CFG_TEMP_FIRST  = 4'd1,
    CFG_TEMP_2_3    = 4'd2,
    CFG_PRESS_FIRST = 4'd3,
    CFG_PRESS_2_3   = 4'd4,
    CFG_PRESS_4_5   = 4'd5,
    CFG_PRESS_6_7   = 4'd6,
    CFG_PRESS_8_9   = 4'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOCAL = 2'd1,
    ST_ZERO  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_T1, S_T2, S_T3, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7,
    S_DIV, S_P8, S_P9, S_P10, S_OUT
  } back_state_e;

  typedef struct packed {
    logic        calib_valid;
    logic [15:0] temp_first;
    logic [31:0] temp_2_3;
    logic [15:0] press_first;
    logic [31:0] press_2_3;
    logic [31:0] press_4_5;
    logic [31:0] press_6_7;
    logic [31:0] press_8_9;
  } cfg_t;

  typedef struct packed {
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic        calib;
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;
  } front_item_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        start;
    logic [63:0] n;
    logic [63:0] d;
  } div_req_t;

  function automatic logic [63:0] sx16(input logic [15:0] h);
    return {{48{h[15]}}, h};
  endfunction

  function automatic logic [63:0] sx32(input logic [31:0] w);
    return {{32{w[31]}}, w};
  endfunction

endpackage

>>> design/bsc_mul.sv
module bsc_mul
  import bsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mul_req_t    req_i,
  output logic        done_o,
  output logic [63:0] prod_o
);

  // Low 64 bits of a 64x64 product from three 32x32 partial products,
  // one per cycle, each registered before it is accumulated.
  logic        busy_q, busy_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        done_q, done_d;
  logic [63:0] a_q, a_d, b_q, b_d, pp_q, pp_d, acc_q, acc_d;
  logic [31:0] x, y;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    x      = a_q[31:0];
    y      = b_q[31:0];
    case (cnt_q)
      2'd1: y = b_q[63:32];
      2'd2: x = a_q[63:32];
      default: ;
    endcase
    pp_d = {32'd0, x} * {32'd0, y};
    if (busy_q) begin
      cnt_d = cnt_q + 2'd1;
      case (cnt_q)
        2'd1: acc_d = pp_q;
        2'd2: acc_d = acc_q + {pp_q[31:0], 32'd0};
        2'd3: begin
          acc_d  = acc_q + {pp_q[31:0], 32'd0};
          done_d = 1'b1;
          busy_d = 1'b0;
        end
        default: ;
      endcase
    end else if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 2'd0;
      a_d    = req_i.a;
      b_d    = req_i.b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 2'd0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    pp_q  <= pp_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

>>> design/bsc_div.sv
module bsc_div
  import bsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  div_req_t    req_i,
  output logic        done_o,
  output logic [63:0] quo_o
);

  // Signed division truncating toward zero: restoring division of the
  // magnitudes, one quotient bit per cycle.
  logic        busy_q, busy_d, done_q, done_d, neg_q, neg_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] ad_q, ad_d, rem_q, rem_d, quo_q, quo_d;
  logic [64:0] sh, diff;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    ad_d   = ad_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    sh     = {rem_q, quo_q[63]};
    diff   = sh - {1'b0, ad_q};
    if (busy_q) begin
      if (!diff[64]) begin
        rem_d = diff[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = sh[63:0];
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 6'd0;
      rem_d  = 64'd0;
      quo_d  = req_i.n[63] ? (64'd0 - req_i.n) : req_i.n;
      ad_d   = req_i.d[63] ? (64'd0 - req_i.d) : req_i.d;
      neg_d  = req_i.n[63] ^ req_i.d[63];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    ad_q  <= ad_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? (64'd0 - quo_q) : quo_q;

endmodule

>>> design/bsc_front.sv
module bsc_front
  import bsc_pkg::*;
#(
  parameter int unsigned Depth = FRONT_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  in_item_t    in_data_i,
  output logic        full,
  input  logic        calib_i,
  output logic        item_valid_o,
  output front_item_t item_o,
  input  logic        item_pop_i
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  front_item_t       mem_q [Depth];
  logic [AW-1:0]     wr_q, rd_q;
  logic [CW-1:0]     cnt_q;
  logic              wr_en, rd_en;

  assign full         = (cnt_q == CW'(Depth));
  assign item_valid_o = (cnt_q != '0);
  assign wr_en        = push && !full;
  assign rd_en        = item_pop_i && item_valid_o;
  assign item_o       = mem_q[rd_q];

  // Items are tagged with the calibration state when the transaction
  // is accepted; the back part routes uncalibrated ones straight out.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= '{calib: calib_i, raw_pressure: in_data_i.raw_pressure,
                       raw_temperature: in_data_i.raw_temperature};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_en) wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + AW'(1);
      if (rd_en) rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + AW'(1);
      if (wr_en && !rd_en) cnt_q <= cnt_q + CW'(1);
      else if (!wr_en && rd_en) cnt_q <= cnt_q - CW'(1);
    end
  end

endmodule

>>> design/bsc_back.sv
module bsc_back
  import bsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        item_valid_i,
  input  front_item_t item_i,
  output logic        item_pop_o,
  output mul_req_t    mul_req_o,
  input  logic        mul_done_i,
  input  logic [63:0] mul_prod_i,
  output div_req_t    div_req_o,
  input  logic        div_done_i,
  input  logic [63:0] div_quo_i,
  output logic        empty,
  output out_item_t   out_data_o,
  input  logic        pop
);

  back_state_e state_q, state_d;
  logic        issued_q, issued_d, out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;
  status_e     st_q, st_d;
  logic [19:0] ap_q, ap_d, at_q, at_d;
  logic [31:0] t1_q, t1_d, t2_q, t2_d, tf_q, tf_d;
  logic [63:0] v_q, v_d, a_q, a_d, v2_q, v2_d, dv_q, dv_d, q_q, q_d, s_q, s_d;

  logic        out_free, out_pop;
  logic [31:0] d1, d2, tfin, tc5;
  logic [63:0] div_by, ps, pfin, p_in;
  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

  assign out_pop  = pop && out_valid_q;
  assign out_free = !out_valid_q || out_pop;

  assign p1 = {48'd0, cfg_i.press_first};
  assign p2 = sx16(cfg_i.press_2_3[15:0]);
  assign p3 = sx16(cfg_i.press_2_3[31:16]);
  assign p4 = sx16(cfg_i.press_4_5[15:0]);
  assign p5 = sx16(cfg_i.press_4_5[31:16]);
  assign p6 = sx16(cfg_i.press_6_7[15:0]);
  assign p7 = sx16(cfg_i.press_6_7[31:16]);
  assign p8 = sx16(cfg_i.press_8_9[15:0]);
  assign p9 = sx16(cfg_i.press_8_9[31:16]);

  assign d1     = 32'(at_q >> 3) - {15'd0, cfg_i.temp_first, 1'b0};
  assign d2     = 32'(at_q >> 4) - {16'd0, cfg_i.temp_first};
  assign tfin   = t1_q + 32'($signed(mul_prod_i[31:0]) >>> 14);
  assign div_by = 64'($signed(mul_prod_i) >>> P_DIV_SH);
  assign ps     = 64'($signed(q_q) >>> 13);
  assign p_in   = P_BASE - {44'd0, ap_q};
  assign pfin   = 64'($signed(s_q) >>> 8) + {p7[59:0], 4'd0};
  assign tc5    = {tf_q[29:0], 2'd0} + tf_q + T_ROUND;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (item_valid_i && item_i.calib) state_d = S_T1;
      S_T1:   if (mul_done_i) state_d = S_T2;
      S_T2:   if (mul_done_i) state_d = S_T3;
      S_T3:   if (mul_done_i) state_d = S_P1;
      S_P1:   if (mul_done_i) state_d = S_P2;
      S_P2:   if (mul_done_i) state_d = S_P3;
      S_P3:   if (mul_done_i) state_d = S_P4;
      S_P4:   if (mul_done_i) state_d = S_P5;
      S_P5:   if (mul_done_i) state_d = S_P6;
      S_P6:   if (mul_done_i) state_d = (div_by == 64'd0) ? S_OUT : S_P7;
      S_P7:   if (mul_done_i) state_d = S_DIV;
      S_DIV:  if (div_done_i) state_d = S_P8;
      S_P8:   if (mul_done_i) state_d = S_P9;
      S_P9:   if (mul_done_i) state_d = S_P10;
      S_P10:  if (mul_done_i) state_d = S_OUT;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and handshakes.
  always_comb begin
    issued_d    = issued_q;
    out_valid_d = out_valid_q && !out_pop;
    out_d       = out_q;
    st_d = st_q; ap_d = ap_q; at_d = at_q;
    t1_d = t1_q; t2_d = t2_q; tf_d = tf_q;
    v_d = v_q; a_d = a_q; v2_d = v2_q; dv_d = dv_q; q_d = q_q; s_d = s_q;
    item_pop_o      = 1'b0;
    mul_req_o.start = 1'b0;
    mul_req_o.a     = 64'd0;
    mul_req_o.b     = 64'd0;
    div_req_o.start = 1'b0;
    div_req_o.n     = a_q;
    div_req_o.d     = dv_q;

    unique case (state_q)
      S_T1:  begin mul_req_o.a = {32'd0, d1}; mul_req_o.b = sx16(cfg_i.temp_2_3[15:0]); end
      S_T2:  begin mul_req_o.a = {32'd0, d2}; mul_req_o.b = {32'd0, d2}; end
      S_T3:  begin mul_req_o.a = {32'd0, t2_q}; mul_req_o.b = sx16(cfg_i.temp_2_3[31:16]); end
      S_P1:  begin mul_req_o.a = v_q; mul_req_o.b = v_q; end
      S_P2:  begin mul_req_o.a = a_q; mul_req_o.b = p6; end
      S_P3:  begin mul_req_o.a = v_q; mul_req_o.b = p5; end
      S_P4:  begin mul_req_o.a = a_q; mul_req_o.b = p3; end
      S_P5:  begin mul_req_o.a = v_q; mul_req_o.b = p2; end
      S_P6:  begin mul_req_o.a = a_q; mul_req_o.b = p1; end
      S_P7:  begin mul_req_o.a = {p_in[32:0], 31'd0} - v2_q; mul_req_o.b = P_SCALE; end
      S_P8:  begin mul_req_o.a = p9; mul_req_o.b = ps; end
      S_P9:  begin mul_req_o.a = a_q; mul_req_o.b = ps; end
      S_P10: begin mul_req_o.a = p8; mul_req_o.b = q_q; end
      default: ;
    endcase

    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          if (!item_i.calib) begin
            if (out_free) begin
              item_pop_o              = 1'b1;
              out_valid_d             = 1'b1;
              out_d.temperature_centi = 32'sd0;
              out_d.pressure_q24_8    = 32'd0;
              out_d.status            = ST_NOCAL;
            end
          end else begin
            item_pop_o = 1'b1;
            ap_d       = item_i.raw_pressure;
            at_d       = item_i.raw_temperature;
            st_d       = ST_OK;
          end
        end
      end
      S_DIV: begin
        if (!issued_q) begin
          div_req_o.start = 1'b1;
          issued_d        = 1'b1;
        end else if (div_done_i) begin
          issued_d = 1'b0;
          q_d      = div_quo_i;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_d.status = st_q;
          if (st_q == ST_OK) begin
            out_d.temperature_centi = 32'($signed(tc5) >>> 8);
            if (pfin[63])          out_d.pressure_q24_8 = 32'd0;
            else if (|pfin[62:32]) out_d.pressure_q24_8 = 32'hFFFF_FFFF;
            else                   out_d.pressure_q24_8 = pfin[31:0];
          end else begin
            out_d.temperature_centi = 32'sd0;
            out_d.pressure_q24_8    = 32'd0;
          end
        end
      end
      default: begin
        // Every other state is one multiplication: issue it once, then
        // take the product when the unit reports it.
        if (!issued_q) begin
          mul_req_o.start = 1'b1;
          issued_d        = 1'b1;
        end else if (mul_done_i) begin
          issued_d = 1'b0;
          case (state_q)
            S_T1:  t1_d = 32'($signed(mul_prod_i[31:0]) >>> 11);
            S_T2:  t2_d = 32'($signed(mul_prod_i[31:0]) >>> 12);
            S_T3:  begin tf_d = tfin; v_d = sx32(tfin) - T_OFFSET; end
            S_P1:  a_d = mul_prod_i;
            S_P2:  v2_d = mul_prod_i;
            S_P3:  v2_d = v2_q + {mul_prod_i[46:0], 17'd0} + {p4[28:0], 35'd0};
            S_P4:  a_d = 64'($signed(mul_prod_i) >>> 8);
            S_P5:  a_d = a_q + {mul_prod_i[51:0], 12'd0} + (64'd1 << P_ONE_SH);
            S_P6:  begin
              dv_d = div_by;
              if (div_by == 64'd0) st_d = ST_ZERO;
            end
            S_P7:  a_d = mul_prod_i;
            S_P8:  a_d = mul_prod_i;
            S_P9:  a_d = 64'($signed(mul_prod_i) >>> 25);
            S_P10: s_d = q_q + a_q + 64'($signed(mul_prod_i) >>> 19);
            default: ;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issued_q    <= issued_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d; st_q <= st_d; ap_q <= ap_d; at_q <= at_d;
    t1_q <= t1_d; t2_q <= t2_d; tf_q <= tf_d;
    v_q <= v_d; a_q <= a_d; v2_q <= v2_d; dv_q <= dv_d; q_q <= q_d; s_q <= s_d;
  end

  assign empty      = !out_valid_q;
  assign out_data_o = out_q;

  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !issued_q)
    else $error("request outstanding while idle");

  a_mul_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done_i |-> issued_q && state_q != S_IDLE && state_q != S_DIV && state_q != S_OUT)
    else $error("product arrived without a request");

  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done_i |-> state_q == S_DIV && issued_q)
    else $error("quotient arrived outside the divide step");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status != ST_OK |->
      out_q.temperature_centi == 32'sd0 && out_q.pressure_q24_8 == 32'd0)
    else $error("error result carries nonzero data");

endmodule

>>> design/barometric_sensor_compensation.sv
// A calibrated item takes ten multiplications, a divide step on the radix-2
// divider and three more multiplications; a zero divisor ends the work after
// nine multiplications. The back part works on one calibrated item at a time;
// uncalibrated items pass at one per cycle while the back part is idle and the
// output is empty or popped. Reset: asynchronous, active low; clears queues,
// sequencer, config.
module barometric_sensor_compensation
  import bsc_pkg::*;
#(
  parameter int unsigned FrontDepth = FRONT_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  push,
  input  in_item_t              in_data_i,
  output logic                  full,
  output logic                  empty,
  output out_item_t             out_data_o,
  input  logic                  pop
);

  cfg_t        cfg_q;
  logic        item_valid, item_pop, mul_done, div_done;
  front_item_t item;
  mul_req_t    mul_req;
  div_req_t    div_req;
  logic [63:0] mul_prod, div_quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CALIB_VALID: cfg_q.calib_valid <= cfg_wdata_i[0];
        CFG_TEMP_FIRST:  cfg_q.temp_first  <= cfg_wdata_i[15:0];
        CFG_TEMP_2_3:    cfg_q.temp_2_3    <= cfg_wdata_i;
        CFG_PRESS_FIRST: cfg_q.press_first <= cfg_wdata_i[15:0];
        CFG_PRESS_2_3:   cfg_q.press_2_3   <= cfg_wdata_i;
        CFG_PRESS_4_5:   cfg_q.press_4_5   <= cfg_wdata_i;
        CFG_PRESS_6_7:   cfg_q.press_6_7   <= cfg_wdata_i;
        CFG_PRESS_8_9:   cfg_q.press_8_9   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  bsc_front #(.Depth(FrontDepth)) u_front (
    .clk_i, .rst_ni, .push, .in_data_i, .full,
    .calib_i(cfg_q.calib_valid), .item_valid_o(item_valid), .item_o(item),
    .item_pop_i(item_pop)
  );

  bsc_mul u_mul (
    .clk_i, .rst_ni, .req_i(mul_req), .done_o(mul_done), .prod_o(mul_prod)
  );

  bsc_div u_div (
    .clk_i, .rst_ni, .req_i(div_req), .done_o(div_done), .quo_o(div_quo)
  );

  bsc_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .item_valid_i(item_valid), .item_i(item), .item_pop_o(item_pop),
    .mul_req_o(mul_req), .mul_done_i(mul_done), .mul_prod_i(mul_prod),
    .div_req_o(div_req), .div_done_i(div_done), .div_quo_i(div_quo),
    .empty, .out_data_o, .pop
  );

endmodule
